### hw/rtl/mir_pkg.sv
// Shared types and constants for the MTPA d-axis reference ramp.
package mir_pkg;

  localparam int unsigned FILT_SHIFT = 7;
  localparam logic [7:0] CNT_FIRE = 8'd200;
  localparam logic [7:0] CNT_RELOAD = 8'd101;
  localparam logic signed [16:0] RAMP_STEP = 17'sd50;
  localparam logic signed [16:0] REF_MAX = 17'sd32767;
  localparam logic signed [16:0] REF_MIN = -17'sd32768;
  localparam logic [14:0] TORQUE_THR_RESET = 15'd5000;
  localparam logic [14:0] MAG_LIMIT_RESET = 15'd2500;
  localparam logic [14:0] MAG_SAT = 15'h7FFF;

  typedef enum logic [0:0] {
    CFG_TORQUE_THRESHOLD = 1'b0,
    CFG_MAGNETIZING_LIMIT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] target;
    logic signed [15:0] filtered;
  } tgt_t;

endpackage

### hw/rtl/mir_filter_target.sv
// Current low-pass filter and d-axis target computation.
module mir_filter_target (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic signed [15:0] iq,
  input  logic signed [15:0] vq,
  input  logic [14:0]        torque_thr,
  input  logic [14:0]        mag_limit,
  output mir_pkg::tgt_t      tgt
);
  import mir_pkg::*;

  logic signed [15:0] filt_r;
  logic signed [15:0] filt_nxt;
  logic signed [23:0] acc;
  logic [16:0]        mag17;
  logic [14:0]        mag15;
  logic [14:0]        diff;
  logic [14:0]        mag_t;
  logic               above;

  always_comb begin
    acc = {filt_r[15], filt_r, 7'b0} - {{8{filt_r[15]}}, filt_r}
          + {{8{iq[15]}}, iq};
    filt_nxt = 16'(acc >>> FILT_SHIFT);
    mag17 = filt_nxt[15] ? 17'(-{filt_nxt[15], filt_nxt}) : {1'b0, filt_nxt};
    mag15 = mag17[16] || mag17[15] ? MAG_SAT : mag17[14:0];
    above = mag15 > torque_thr;
    diff = mag15 - torque_thr;
    if (!above) begin
      mag_t = '0;
    end else if (diff > mag_limit) begin
      mag_t = mag_limit;
    end else begin
      mag_t = diff;
    end
    tgt.target = vq[15] ? -$signed({1'b0, mag_t}) : $signed({1'b0, mag_t});
    tgt.filtered = filt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r <= '0;
    end else if (adv) begin
      filt_r <= filt_nxt;
    end
  end

endmodule

### hw/rtl/mir_ramp.sv
// Rate-limited d-axis reference with rise and fall step counters.
module mir_ramp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic signed [15:0] target,
  output logic signed [15:0] ref_nxt
);
  import mir_pkg::*;

  logic signed [15:0] ref_r;
  logic [7:0]         rise_r;
  logic [7:0]         rise_nxt;
  logic [7:0]         fall_r;
  logic [7:0]         fall_nxt;
  logic [7:0]         rise_inc;
  logic [7:0]         fall_inc;
  logic signed [16:0] up;
  logic signed [16:0] dn;
  logic signed [15:0] up_sat;
  logic signed [15:0] dn_sat;

  always_comb begin
    rise_inc = rise_r + 8'd1;
    fall_inc = fall_r + 8'd1;
    up = {ref_r[15], ref_r} + RAMP_STEP;
    dn = {ref_r[15], ref_r} - RAMP_STEP;
    up_sat = (up > REF_MAX) ? 16'(REF_MAX) : up[15:0];
    dn_sat = (dn < REF_MIN) ? 16'(REF_MIN) : dn[15:0];
    rise_nxt = rise_r;
    fall_nxt = fall_r;
    ref_nxt = ref_r;
    if (ref_r < target) begin
      rise_nxt = rise_inc;
      if (rise_inc > CNT_FIRE) begin
        rise_nxt = CNT_RELOAD;
        fall_nxt = '0;
        ref_nxt = up_sat;
      end
    end else if (ref_r > target) begin
      fall_nxt = fall_inc;
      if (fall_inc > CNT_FIRE) begin
        rise_nxt = '0;
        fall_nxt = CNT_RELOAD;
        ref_nxt = (dn_sat < target) ? target : dn_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= '0;
      rise_r <= '0;
      fall_r <= '0;
    end else if (adv) begin
      ref_r <= ref_nxt;
      rise_r <= rise_nxt;
      fall_r <= fall_nxt;
    end
  end

endmodule

### hw/rtl/mtpa_id_reference_ramp_core.sv
// Top level of the MTPA d-axis current reference with ramp limiting.
// One transaction per control tick: the block takes a new input every clock
// cycle while the output is not stalled by out_ready, and delivers its result
// through the input register and then the result register. The update of
// the filter and ramp state between those registers sets the rate of one item
// per cycle. Configuration writes take effect on the next clock edge.
module mtpa_id_reference_ramp_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [14:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_iq_measured,
  input  logic signed [15:0] in_vq_command,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_id_reference,
  output logic signed [15:0] out_id_target,
  output logic signed [15:0] out_filtered_iq
);
  import mir_pkg::*;

  logic [14:0]        torque_thr_r;
  logic [14:0]        mag_limit_r;
  logic               s1_valid_r;
  logic signed [15:0] s1_iq_r;
  logic signed [15:0] s1_vq_r;
  logic               out_valid_r;
  logic signed [15:0] out_ref_r;
  logic signed [15:0] out_tgt_r;
  logic signed [15:0] out_filt_r;
  logic               adv;
  tgt_t               tgt;
  logic signed [15:0] ref_nxt;

  assign adv = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;
  assign out_valid = out_valid_r;
  assign out_id_reference = out_ref_r;
  assign out_id_target = out_tgt_r;
  assign out_filtered_iq = out_filt_r;

  mir_filter_target u_filter_target (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .iq        (s1_iq_r),
    .vq        (s1_vq_r),
    .torque_thr(torque_thr_r),
    .mag_limit (mag_limit_r),
    .tgt       (tgt)
  );

  mir_ramp u_ramp (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .target (tgt.target),
    .ref_nxt(ref_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      torque_thr_r <= TORQUE_THR_RESET;
      mag_limit_r <= MAG_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TORQUE_THRESHOLD: torque_thr_r <= cfg_wdata;
        CFG_MAGNETIZING_LIMIT: mag_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_iq_r <= in_iq_measured;
      s1_vq_r <= in_vq_command;
    end
    if (adv) begin
      out_ref_r <= ref_nxt;
      out_tgt_r <= tgt.target;
      out_filt_r <= tgt.filtered;
    end
  end

endmodule
